[rtl/core/iax_pkg.sv]
// Package for the indexed array list: sizes, command and status codes,
// and the operation bundle broadcast from the control to the cell row.
// No dependencies.
`default_nettype none

package iax_pkg;

    // List capacity and derived widths
    localparam int CAPACITY   = 256;
    localparam int DATA_W     = 32;
    localparam int POS_W      = 9;
    localparam int OUT_CNT_W  = 9;
    localparam int CNT_W      = $clog2(CAPACITY + 1);
    localparam int CMP_W      = (CNT_W > POS_W) ? CNT_W : POS_W;

    // Read gather tree: groups of cells ORed into registers
    localparam int GROUP_SIZE = 16;
    localparam int NUM_GROUPS = (CAPACITY + GROUP_SIZE - 1) / GROUP_SIZE;

    // Stream packing
    localparam int IN_TDATA_W  = 48;
    localparam int OUT_TDATA_W = 48;

    typedef enum logic [1:0] {
        CMD_APPEND = 2'd0,
        CMD_INSERT = 2'd1,
        CMD_ERASE  = 2'd2,
        CMD_READ   = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        STATUS_OK     = 2'd0,
        STATUS_FULL   = 2'd1,
        STATUS_BADIDX = 2'd2
    } status_t;

    // One operation as seen by every cell in the row
    typedef struct packed {
        logic              ins;    // store value at pos, move later entries up
        logic              era;    // drop entry at pos, move later entries down
        logic [CMP_W-1:0]  pos;    // target index (count for append)
        logic [DATA_W-1:0] value;
    } op_t;

endpackage

`default_nettype wire

[rtl/core/iax_cell.sv]
// One storage cell of the indexed array list row: holds a single entry and
// trades it with its neighbors on insert and erase. Depends on iax_pkg.
`default_nettype none

module iax_cell (
    input  wire logic                        clk,
    input  wire iax_pkg::op_t                op,
    input  wire logic [iax_pkg::CMP_W-1:0]   idx,
    input  wire logic [iax_pkg::DATA_W-1:0]  left,
    input  wire logic [iax_pkg::DATA_W-1:0]  right,
    output logic      [iax_pkg::DATA_W-1:0]  word,
    output logic      [iax_pkg::DATA_W-1:0]  pick
);

    logic [iax_pkg::DATA_W-1:0] data_reg;
    logic [iax_pkg::DATA_W-1:0] data_next;
    logic                       hit;

    assign hit = (idx == op.pos);

    // Choose load, shift up, shift down or hold
    always_comb
    begin
        data_next = data_reg;
        if (op.ins && hit)
        begin
            data_next = op.value;
        end
        else if (op.ins && (idx > op.pos))
        begin
            data_next = left;
        end
        else if (op.era && (idx >= op.pos))
        begin
            data_next = right;
        end
    end

    // Hold the entry
    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign word = data_reg;

    // Offer the entry to the read tree when addressed
    assign pick = hit ? data_reg : '0;

endmodule

`default_nettype wire

[rtl/core/iax_gather.sv]
// Read tree of the indexed array list: ORs the picked cell words in groups
// into registers, then ORs the groups. Depends on iax_pkg.
`default_nettype none

module iax_gather (
    input  wire logic                        clk,
    input  wire logic                        capture,
    input  wire logic [iax_pkg::DATA_W-1:0]  picks [iax_pkg::CAPACITY],
    output logic      [iax_pkg::DATA_W-1:0]  word
);

    logic [iax_pkg::DATA_W-1:0] grp_reg  [iax_pkg::NUM_GROUPS];
    logic [iax_pkg::DATA_W-1:0] grp_next [iax_pkg::NUM_GROUPS];

    // Reduce each group of cells
    always_comb
    begin
        for (int g = 0; g < iax_pkg::NUM_GROUPS; g++)
        begin
            grp_next[g] = '0;
            for (int k = 0; k < iax_pkg::GROUP_SIZE; k++)
            begin
                if (g * iax_pkg::GROUP_SIZE + k < iax_pkg::CAPACITY)
                begin
                    grp_next[g] = grp_next[g] | picks[g * iax_pkg::GROUP_SIZE + k];
                end
            end
        end
    end

    // Hold group results
    always_ff @(posedge clk)
    begin
        if (capture)
        begin
            for (int g = 0; g < iax_pkg::NUM_GROUPS; g++)
            begin
                grp_reg[g] <= grp_next[g];
            end
        end
    end

    // Combine the groups
    always_comb
    begin
        word = '0;
        for (int g = 0; g < iax_pkg::NUM_GROUPS; g++)
        begin
            word = word | grp_reg[g];
        end
    end

endmodule

`default_nettype wire

[rtl/core/indexed_array_list.sv]
// Indexed array list top level: command decode, live count, cell row and
// result register. Depends on iax_pkg, iax_cell and iax_gather.
//
// Usage:
//   Command beats enter on s_tvalid/s_tready/s_tdata (append, insert at
//   index, erase at index, read at index). Each beat returns exactly one
//   result beat on m_tvalid/m_tready/m_tdata with the read data, the live
//   count after the operation and a status (ok, full, bad index).
//   Insert and erase move every later entry one place in the cell row in
//   the accept cycle, each cell taking its neighbor's word.
//   A result is presented once the read tree's group registers have loaded at
//   the accept edge and the combined word has been registered into the
//   output; that waits while the output register is still full.
//   s_tready drops while the read tree is being combined, so no new command
//   is taken until the previous result has been registered into the output.
//   A command may be accepted while the previous result still waits in the
//   output register; if m_tready stays low the block holds the next result
//   and stops taking commands until the output register frees up.
//   Reset clears the live count and the handshake state; the entries are
//   not cleared, as only live, written entries are ever read.
`default_nettype none

module indexed_array_list (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // command: [1:0] command, [10:2] position, [42:11] value, [47:43] zero
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [47:0] s_tdata,
    // result: [31:0] read_data, [40:32] count, [42:41] status, [47:43] zero
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [47:0]      m_tdata
);

    typedef enum logic {
        S_IDLE,
        S_GATHER
    } state_t;

    state_t                         state_reg;
    logic                           m_tvalid_reg;
    logic [iax_pkg::OUT_TDATA_W-1:0] m_tdata_reg;
    logic [iax_pkg::CNT_W-1:0]      count_reg;
    logic [iax_pkg::CNT_W-1:0]      count_next;
    iax_pkg::status_t               status_reg;
    iax_pkg::status_t               status_next;
    logic                           rd_ok_reg;
    logic                           rd_ok_next;

    logic                           accept;
    iax_pkg::cmd_t                  cmd;
    logic [iax_pkg::CMP_W-1:0]      pos;
    logic [iax_pkg::CMP_W-1:0]      cnt;
    logic [iax_pkg::DATA_W-1:0]     value;
    logic                           full;
    iax_pkg::op_t                   op;

    logic [iax_pkg::DATA_W-1:0]     cell_word [iax_pkg::CAPACITY];
    logic [iax_pkg::DATA_W-1:0]     cell_pick [iax_pkg::CAPACITY];
    logic [iax_pkg::DATA_W-1:0]     gather_word;
    logic [iax_pkg::DATA_W-1:0]     rd_data;
    logic                           out_free;

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;

    // Unpack the command beat
    assign cmd   = iax_pkg::cmd_t'(s_tdata[1:0]);
    assign pos   = iax_pkg::CMP_W'(s_tdata[10:2]);
    assign value = s_tdata[42:11];
    assign cnt   = iax_pkg::CMP_W'(count_reg);
    assign full  = (cnt >= iax_pkg::CMP_W'(iax_pkg::CAPACITY));

    // Decode the command against the live count
    always_comb
    begin
        op          = '0;
        op.value    = value;
        op.pos      = pos;
        count_next  = count_reg;
        status_next = iax_pkg::STATUS_OK;
        rd_ok_next  = 1'b0;
        unique case (cmd)
            iax_pkg::CMD_APPEND:
            begin
                op.pos = cnt;
                if (full)
                begin
                    status_next = iax_pkg::STATUS_FULL;
                end
                else
                begin
                    op.ins     = accept;
                    count_next = count_reg + 1'b1;
                end
            end
            iax_pkg::CMD_INSERT:
            begin
                if (pos > cnt)
                begin
                    status_next = iax_pkg::STATUS_BADIDX;
                end
                else if (full)
                begin
                    status_next = iax_pkg::STATUS_FULL;
                end
                else
                begin
                    op.ins     = accept;
                    count_next = count_reg + 1'b1;
                end
            end
            iax_pkg::CMD_ERASE:
            begin
                if (pos >= cnt)
                begin
                    status_next = iax_pkg::STATUS_BADIDX;
                end
                else
                begin
                    op.era     = accept;
                    count_next = count_reg - 1'b1;
                end
            end
            iax_pkg::CMD_READ:
            begin
                if (pos >= cnt)
                begin
                    status_next = iax_pkg::STATUS_BADIDX;
                end
                else
                begin
                    rd_ok_next = 1'b1;
                end
            end
            default:
            begin
                status_next = iax_pkg::STATUS_BADIDX;
            end
        endcase
    end

    // Row of cells, each wired to its neighbors
    for (genvar i = 0; i < iax_pkg::CAPACITY; i++)
    begin : g_cell
        logic [iax_pkg::DATA_W-1:0] left_word;
        logic [iax_pkg::DATA_W-1:0] right_word;

        if (i == 0)
        begin : g_first
            assign left_word = '0;
        end
        else
        begin : g_mid_left
            assign left_word = cell_word[i-1];
        end

        if (i == iax_pkg::CAPACITY - 1)
        begin : g_last
            assign right_word = cell_word[i];
        end
        else
        begin : g_mid_right
            assign right_word = cell_word[i+1];
        end

        iax_cell u_cell (
            .clk   (clk),
            .op    (op),
            .idx   (iax_pkg::CMP_W'(i)),
            .left  (left_word),
            .right (right_word),
            .word  (cell_word[i]),
            .pick  (cell_pick[i])
        );
    end

    // Registered read tree
    iax_gather u_gather (
        .clk     (clk),
        .capture (accept),
        .picks   (cell_pick),
        .word    (gather_word)
    );

    assign rd_data = rd_ok_reg ? gather_word : '0;

    // Control state, live count and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            m_tvalid_reg <= 1'b0;
            m_tdata_reg  <= '0;
            count_reg    <= '0;
            status_reg   <= iax_pkg::STATUS_OK;
            rd_ok_reg    <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    // Drop the result beat once it is taken
                    if (m_tvalid_reg && m_tready)
                    begin
                        m_tvalid_reg <= 1'b0;
                    end
                    if (accept)
                    begin
                        count_reg  <= count_next;
                        status_reg <= status_next;
                        rd_ok_reg  <= rd_ok_next;
                        state_reg  <= S_GATHER;
                    end
                end
                S_GATHER:
                begin
                    if (out_free)
                    begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= {5'd0, status_reg,
                                         iax_pkg::OUT_CNT_W'(count_reg), rd_data};
                        state_reg    <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

`default_nettype wire
